// File: hdl/chained_hash_table_engine_assert.svh
// assertion macros for the chained hash table engine
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
// implication checked at every edge outside reset
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define CHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/cht_pkg.sv
// shared types and codes for the chained hash table engine
package cht_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, start modulo
        logic mod_step;  // one restoring division step
        logic hash_fix;  // correct negative remainder, fetch fill
        logic rd_entry;  // read chain entry at scan index
        logic cmp;       // compare registered entry, advance scan
        logic shift;     // read entry one above for delete compaction
        logic shift_wr;  // write shifted entry back
        logic finish;    // write fill and form result
        logic clear;     // start clearing fills
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mod_done;
        logic scan_end;  // scan index reached fill
        logic hit;
        logic shift_end;
        logic clr_done;
        logic [1:0] op;
    } t_stat;
endpackage

// File: hdl/chained_hash_table_engine.sv
// top level of the chained hash table engine
// Hash table with separate chaining. A request (i_req_valid/o_req_ready)
// carries i_opcode (0 insert, 1 search, 2 delete, 3 acts as search) and a
// signed i_key_value. The bucket is the key modulo the configured bucket
// count, non-negative. One result per request on o_res_valid/i_res_ready:
// status, bucket index, position and chain length after the operation.
// From the accepting edge the restoring divider forms one quotient bit per
// cycle, then a fix step corrects the remainder; for search and delete each
// entry scanned is read and compared, each entry shifted down is read and
// written back, and a closing check ends the scan; last the result register
// is loaded. One request at a time, so a new request is taken only after the
// previous one has loaded its result register.
// i_cfg_we writes the bucket count and, when idle, starts a sweep clearing
// every bucket fill count; no requests are taken meanwhile.
// Reset sets the count to 16 and runs the same sweep. The result is held
// in the output register while the receiver stalls; the next request is
// still taken and worked on, and its finished result waits until the
// output register drains, so no further request is taken until then.
module chained_hash_table_engine #(
    parameter int MAX_BUCKETS = 64,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_opcode,
    input  logic signed [31:0] i_key_value,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_bucket_index,
    output logic [3:0]  o_position,
    output logic [3:0]  o_chain_length
);
    import cht_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_free;

    // controller
    cht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_req_valid),
        .i_cfg_we(i_cfg_we), .i_out_free(w_out_free), .i_stat(w_stat),
        .o_req_ready(o_req_ready), .o_cmd(w_cmd)
    );

    // datapath
    cht_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_opcode(i_opcode), .i_key_value(i_key_value),
        .i_out_ready(i_res_ready), .o_stat(w_stat), .o_out_free(w_out_free),
        .o_out_valid(o_res_valid), .o_status(o_status),
        .o_bucket_index(o_bucket_index), .o_position(o_position),
        .o_chain_length(o_chain_length)
    );
endmodule

// File: hdl/cht_ctrl.sv
// controller state machine of the chained hash table engine
module cht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_cfg_we,
    input  logic          i_out_free,
    input  cht_pkg::t_stat i_stat,
    output logic          o_req_ready,
    output cht_pkg::t_cmd o_cmd
);
    import cht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_FIX, S_FETCH, S_CMP, S_SRD, S_SWR, S_DONE
    } t_state;

    t_state r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE) && !i_cfg_we;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_CLEAR;
                end else if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.hash_fix = 1'b1;
                n_state = (i_stat.op == OP_INSERT) ? S_DONE : S_FETCH;
            end
            S_FETCH: begin
                if (i_stat.scan_end) n_state = S_DONE;
                else begin
                    o_cmd.rd_entry = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.hit)
                    n_state = (i_stat.op == OP_DELETE) ? S_SRD : S_DONE;
                else n_state = S_FETCH;
            end
            S_SRD: begin
                if (i_stat.shift_end) n_state = S_DONE;
                else begin
                    o_cmd.shift = 1'b1;
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SRD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register, reset clears the fill counts first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end
endmodule

// File: hdl/cht_datapath.sv
// datapath of the chained hash table engine: modulo unit, chain memory, fills
module cht_datapath #(
    parameter int MAX_BUCKETS = 64,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cht_pkg::t_cmd i_cmd,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_data,
    input  logic [1:0]    i_opcode,
    input  logic signed [31:0] i_key_value,
    input  logic          i_out_ready,
    output cht_pkg::t_stat o_stat,
    output logic          o_out_free,
    output logic          o_out_valid,
    output logic [2:0]    o_status,
    output logic [5:0]    o_bucket_index,
    output logic [3:0]    o_position,
    output logic [3:0]    o_chain_length
);
    import cht_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int FW = $clog2(CHAIN_DEPTH + 1);
    localparam int NW = $clog2(MAX_BUCKETS + 1);

    logic [6:0]    r_cfg;
    logic [NW-1:0] w_n;
    logic [1:0]    r_op;
    logic [31:0]   r_key, r_quo;
    logic [NW:0]   r_rem;
    logic [5:0]    r_cnt;
    logic          r_neg;
    logic [BW-1:0] r_bkt;
    logic [FW-1:0] r_fill, r_idx;
    logic [FW-1:0] r_hpos;
    logic [31:0]   r_entry;
    logic          r_hit;
    logic [FW-1:0] r_fills [MAX_BUCKETS];
    logic [31:0]   r_mem [MAX_BUCKETS*CHAIN_DEPTH];
    logic [BW-1:0] r_clr;
    logic          r_clr_busy;
    logic          r_ovalid;
    logic [NW:0]   w_trial;
    logic [31:0]   w_mag;

    // bucket count in use: zero treated as one, saturated to the maximum
    always_comb begin
        if (r_cfg == 7'd0) w_n = NW'(1);
        else if (32'(r_cfg) > 32'(MAX_BUCKETS)) w_n = NW'(MAX_BUCKETS);
        else w_n = NW'(r_cfg);
    end

    assign w_mag = i_key_value[31] ? (32'd0 - i_key_value) : i_key_value;
    assign w_trial = {r_rem[NW-1:0], r_quo[31]};

    assign o_stat.mod_done = (r_cnt == 6'd31);
    assign o_stat.scan_end = (r_idx >= r_fill);
    assign o_stat.hit = (r_entry == r_key);
    assign o_stat.shift_end = (32'(r_idx) + 32'd1 >= 32'(r_fill));
    assign o_stat.clr_done = !r_clr_busy;
    assign o_stat.op = r_op;
    assign o_out_free = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= 7'd16;
        else if (i_cfg_we) r_cfg <= i_cfg_data;
    end

    // fill clearing sweep, one bucket per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_busy <= 1'b1;
            r_clr <= '0;
        end else if (r_clr_busy) begin
            r_clr <= r_clr + BW'(1);
            if (32'(r_clr) == MAX_BUCKETS - 1) r_clr_busy <= 1'b0;
        end
    end

    // restoring modulo unit, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_key <= i_key_value;
            r_neg <= i_key_value[31];
            r_quo <= w_mag;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mod_step) begin
            r_quo <= {r_quo[30:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            if (w_trial >= {1'b0, w_n}) r_rem <= w_trial - {1'b0, w_n};
            else r_rem <= w_trial;
        end
        if (i_cmd.hash_fix) begin
            if (r_neg && r_rem != '0) r_bkt <= BW'({1'b0, w_n} - r_rem);
            else r_bkt <= BW'(r_rem);
            r_idx <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.hash_fix) begin
            if (r_neg && r_rem != '0) r_fill <= r_fills[BW'({1'b0, w_n} - r_rem)];
            else r_fill <= r_fills[BW'(r_rem)];
        end
        if (i_cmd.rd_entry || i_cmd.shift)
            r_entry <= r_mem[{r_bkt, DW'(r_idx + FW'(i_cmd.shift))}];
        if (i_cmd.shift_wr) begin
            r_mem[{r_bkt, DW'(r_idx)}] <= r_entry;
            r_idx <= r_idx + FW'(1);
        end
        // match position is captured at the hit, before compaction moves the index
        if (i_cmd.cmp) begin
            if (o_stat.hit) begin
                r_hit <= 1'b1;
                r_hpos <= r_idx + FW'(1);
            end else r_idx <= r_idx + FW'(1);
        end
        if (i_cmd.finish) begin
            o_bucket_index <= 6'(r_bkt);
            o_position <= '0;
            o_chain_length <= 4'(r_fill);
            if (r_op == OP_INSERT) begin
                if (32'(r_fill) >= CHAIN_DEPTH) o_status <= ST_FULL;
                else begin
                    r_mem[{r_bkt, DW'(r_fill)}] <= r_key;
                    o_status <= ST_INSERTED;
                    o_position <= 4'(r_fill + FW'(1));
                    o_chain_length <= 4'(r_fill + FW'(1));
                end
            end else if (!r_hit) begin
                o_status <= ST_NOT_FOUND;
                o_position <= 4'(r_fill);
            end else if (r_op == OP_DELETE) begin
                o_status <= ST_DELETED;
                o_position <= 4'(r_hpos);
                o_chain_length <= 4'(r_fill - FW'(1));
            end else begin
                o_status <= ST_FOUND;
                o_position <= 4'(r_hpos);
            end
        end
    end

    // fill counts
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) r_fills[r_clr] <= '0;
        else if (i_cmd.finish) begin
            if (r_op == OP_INSERT && 32'(r_fill) < CHAIN_DEPTH)
                r_fills[r_bkt] <= r_fill + FW'(1);
            else if (r_op == OP_DELETE && r_hit)
                r_fills[r_bkt] <= r_fill - FW'(1);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (i_cmd.finish) r_ovalid <= 1'b1;
        else if (i_out_ready) r_ovalid <= 1'b0;
    end

    `include "chained_hash_table_engine_assert.svh"
    `CHT_ASSERT_IMP(a_idx_bound, i_clk, i_rst_n, i_cmd.rd_entry, r_idx < r_fill, "scan past fill")
    `CHT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, i_cmd.finish, 32'(r_fill) <= CHAIN_DEPTH, "fill")
    `CHT_ASSERT_NXT(a_fin_valid, i_clk, i_rst_n, i_cmd.finish, r_ovalid, "result lost")
endmodule

// File: sim/tb_chained_hash_table_engine.sv
// testbench for the chained hash table engine: directed and random requests checked against a table model
module tb_chained_hash_table_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import cht_pkg::*;

    localparam int NBUCK = 64;
    localparam int DEPTH = 8;
    localparam int SETTLE = 80;
    localparam int LIMIT = 600000;
    localparam int LONG_HOLD = 400;
    localparam logic [1:0] OP_ALT_SEARCH = 2'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] bucket;
        logic [3:0] pos;
        logic [3:0] len;
    } t_result;

    // shadow hash table with the queue of expected results
    class hash_scoreboard;
        logic [31:0] chains [NBUCK][DEPTH];
        int unsigned fill [NBUCK];
        int unsigned nbuckets;
        t_result pending_results [$];
        int errors;

        function void configure(logic [6:0] v);
            nbuckets = (v == 0) ? 1 : ((v > NBUCK) ? NBUCK : v);
            foreach (fill[i]) fill[i] = 0;
        endfunction

        // work out the result of one accepted request
        function void note_request(logic [1:0] op, logic [31:0] key);
            int unsigned b, r, f, i, hit_at;
            bit hit;
            t_result res;
            if (!key[31]) b = key % nbuckets;
            else begin
                r = (32'd0 - key) % nbuckets;
                b = (r == 0) ? 0 : nbuckets - r;
            end
            f = fill[b];
            res.pos = 0;
            hit = 0;
            hit_at = 0;
            if (op == OP_INSERT) begin
                if (f >= DEPTH) res.status = ST_FULL;
                else begin
                    chains[b][f] = key;
                    f++;
                    res.pos = f;
                    res.status = ST_INSERTED;
                end
            end else begin
                for (i = 0; i < f; i++) begin
                    if (!hit && chains[b][i] == key) begin
                        hit = 1;
                        hit_at = i;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                    res.pos = f;
                end else if (op == OP_DELETE) begin
                    res.pos = hit_at + 1;
                    for (i = hit_at; i + 1 < f; i++) chains[b][i] = chains[b][i + 1];
                    f--;
                    res.status = ST_DELETED;
                end else begin
                    res.pos = hit_at + 1;
                    res.status = ST_FOUND;
                end
            end
            fill[b] = f;
            res.bucket = b;
            res.len = f;
            pending_results.push_back(res);
        endfunction

        // compare one delivered result with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.bucket !== want.bucket) begin
                $error("bucket_index expected %0d actual %0d", want.bucket, got.bucket);
                errors++;
            end
            if (got.pos !== want.pos) begin
                $error("position expected %0d actual %0d", want.pos, got.pos);
                errors++;
            end
            if (got.len !== want.len) begin
                $error("chain_length expected %0d actual %0d", want.len, got.len);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_req_valid = 0;
    logic        o_req_ready;
    logic [1:0]  i_opcode = 0;
    logic signed [31:0] i_key_value = 0;
    logic        i_cfg_we = 0;
    logic [6:0]  i_cfg_data = 0;
    logic        o_res_valid;
    logic        i_res_ready = 0;
    logic [2:0]  o_status;
    logic [5:0]  o_bucket_index;
    logic [3:0]  o_position;
    logic [3:0]  o_chain_length;

    hash_scoreboard table_sb = new();
    bit idling = 1;
    bit hold_off = 0;
    int cycles = 0;
    logic [31:0] key_pool [12];

    chained_hash_table_engine #(.MAX_BUCKETS(NBUCK), .CHAIN_DEPTH(DEPTH)) DUT (.*);

    initial forever #5 i_clk = ~i_clk;

    // timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            table_sb.check_result({o_status, o_bucket_index, o_position, o_chain_length});
    end

    // receiver back-pressure
    initial begin
        @(posedge i_clk);
        i_res_ready <= 1;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_res_ready <= 0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off = 0;
                i_res_ready <= 1;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                i_res_ready <= 0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_res_ready <= 1;
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send(logic [1:0] op, logic [31:0] key);
        int gap;
        i_req_valid <= 1;
        i_opcode <= op;
        i_key_value <= key;
        do @(posedge i_clk); while (!o_req_ready);
        table_sb.note_request(op, key);
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            i_req_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (table_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write the bucket count once the engine is idle
    task automatic set_buckets(logic [6:0] v);
        i_req_valid <= 0;
        drain();
        do @(posedge i_clk); while (!o_req_ready);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        table_sb.configure(v);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // long receiver stall starts once the phase begins sending
    task automatic random_phase(logic [6:0] nb, int count, bit stall = 0);
        int k, sel;
        logic [1:0] op;
        logic [31:0] key;
        set_buckets(nb);
        if (stall) hold_off = 1;
        foreach (key_pool[j]) key_pool[j] = $urandom();
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            op = (sel < 45) ? OP_INSERT : (sel < 72) ? OP_SEARCH :
                 (sel < 94) ? OP_DELETE : OP_ALT_SEARCH;
            key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 11)];
            send(op, key);
        end
    endtask

    initial begin
        int k;
        table_sb.configure(7'd16);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: fill one bucket past its depth, then search and delete
        set_buckets(7'd4);
        for (k = 0; k < DEPTH + 1; k++) send(OP_INSERT, k * 4);
        send(OP_SEARCH, 32'd12);
        send(OP_SEARCH, 32'd100);
        send(OP_DELETE, 32'd8);
        send(OP_DELETE, 32'd8);
        send(OP_ALT_SEARCH, 32'd28);
        send(OP_INSERT, 32'd8);
        send(OP_INSERT, 32'hFFFF_FFFF);
        send(OP_INSERT, 32'h8000_0000);
        send(OP_INSERT, 32'h7FFF_FFFF);
        send(OP_SEARCH, 32'hFFFF_FFFF);
        // bucket count zero behaves as one, above the maximum saturates
        set_buckets(7'd0);
        send(OP_INSERT, 32'h8000_0001);
        send(OP_SEARCH, 32'h8000_0001);
        set_buckets(7'd127);
        send(OP_INSERT, 32'hFFFF_FFC1);
        send(OP_DELETE, 32'hFFFF_FFC1);
        send(OP_INSERT, 32'h7FFF_FFFF);

        // random phases over several bucket counts
        random_phase(7'd1, 70);
        random_phase(7'd3, 70);
        random_phase(7'd64, 70, 1);
        random_phase(7'd7, 70);
        random_phase(7'd127, 60);
        random_phase(7'd0, 60);
        random_phase(7'($urandom_range(2, 64)), 60);
        idling = 0;
        random_phase(7'd2, 70);

        i_req_valid <= 0;
        drain();
        if (table_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
